// ===== rtl/core/mpbm_pkg.sv =====
// Shared constants, codes and controller/datapath types of the byte matcher.
package mpbm_pkg;

  localparam int STATES          = 1024;
  localparam int SYMBOLS         = 256;
  localparam int PATTERN_IDS     = 1024;
  localparam int MAX_PATTERN_LEN = 64;
  localparam int MAX_RESULTS     = 64;

  localparam int ST_W    = 10;
  localparam int SYM_W   = 8;
  localparam int ID_W    = 10;
  localparam int LEN_W   = 7;
  localparam int POS_W   = 32;
  localparam int GOTO_AW = ST_W + SYM_W;
  localparam int GOTO_W  = ST_W + 1;
  localparam int BUF_AW  = 6;
  localparam int BUF_W   = POS_W + ID_W;
  localparam int CNT_W   = 7;

  typedef enum logic [1:0] {
    OP_LOAD_GOTO = 2'd0,
    OP_LOAD_INFO = 2'd1,
    OP_MATCH     = 2'd2,
    OP_RESTART   = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_LOOKW,
    ST_FAILW,
    ST_INFO,
    ST_INFOW,
    ST_SCAN,
    ST_SCANW,
    ST_PUSH,
    ST_CHAIN,
    ST_DRD,
    ST_DOUT,
    ST_DONE
  } fsm_t;

  typedef struct packed {
    logic clr_wr;
    logic load_goto;
    logic load_info;
    logic restart;
    logic start;
    logic look_rd;
    logic fail_rd;
    logic fail_take;
    logic hit;
    logic info_rd;
    logic cand_load;
    logic scan_rd;
    logic scan_cmp;
    logic push;
    logic chain_adv;
    logic drain_init;
    logic drain_rd;
    logic drain_adv;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic goto_valid;
    logic s_zero;
    logic id_nonzero;
    logic n_full;
    logic scan_done;
    logic dup;
    logic fnext_zero;
    logic chain_done;
    logic n_zero;
    logic drain_last;
  } sts_t;

endpackage

// ===== rtl/core/mpbm_in_if.sv =====
// Input channel: operation and table load or stream byte.
interface mpbm_in_if;
  import mpbm_pkg::*;
  logic             valid;
  logic             ready;
  logic [1:0]       operation;
  logic [ST_W-1:0]  state_index;
  logic [SYM_W-1:0] symbol;
  logic [ST_W-1:0]  target_state;
  logic             target_valid;
  logic [ST_W-1:0]  failure_state;
  logic [ID_W-1:0]  pattern_id;
  logic [LEN_W-1:0] pattern_length;

  modport source (output valid, operation, state_index, symbol, target_state,
                  target_valid, failure_state, pattern_id, pattern_length,
                  input ready);
  modport sink (input valid, operation, state_index, symbol, target_state,
                target_valid, failure_state, pattern_id, pattern_length,
                output ready);
endinterface

// ===== rtl/core/mpbm_out_if.sv =====
// Result channel: one match report per transfer.
interface mpbm_out_if;
  import mpbm_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] start_position;
  logic [ID_W-1:0]  matched_pattern;
  logic             last;

  modport source (output valid, start_position, matched_pattern, last, input ready);
  modport sink (input valid, start_position, matched_pattern, last, output ready);
endinterface

// ===== rtl/core/mpbm_ctrl.sv =====
// Controller state machine sequencing clear, loads, goto walk, report chain and drain.
module mpbm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  mpbm_pkg::op_t   in_op,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  input  mpbm_pkg::sts_t  sts,
  output mpbm_pkg::cmd_t  cmd
);
  import mpbm_pkg::*;

  fsm_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid && in_op == OP_MATCH) state_nxt = ST_LOOK;
      ST_LOOK:  state_nxt = ST_LOOKW;
      ST_LOOKW: state_nxt = (sts.goto_valid || sts.s_zero) ? ST_INFO : ST_FAILW;
      ST_FAILW: state_nxt = ST_LOOK;
      ST_INFO:  state_nxt = ST_INFOW;
      ST_INFOW: state_nxt = (sts.id_nonzero && !sts.n_full) ? ST_SCAN : ST_CHAIN;
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = sts.dup ? ST_CHAIN : ST_PUSH;
        else state_nxt = ST_SCANW;
      end
      ST_SCANW: state_nxt = ST_SCAN;
      ST_PUSH:  state_nxt = ST_CHAIN;
      ST_CHAIN: begin
        if (sts.fnext_zero || sts.chain_done) state_nxt = sts.n_zero ? ST_DONE : ST_DRD;
        else state_nxt = ST_INFO;
      end
      ST_DRD:   state_nxt = ST_DOUT;
      ST_DOUT: begin
        if (out_ready) state_nxt = sts.drain_last ? ST_DONE : ST_DRD;
      end
      ST_DONE:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // commands
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_op)
            OP_LOAD_GOTO: cmd.load_goto = 1'b1;
            OP_LOAD_INFO: cmd.load_info = 1'b1;
            OP_MATCH:     cmd.start     = 1'b1;
            OP_RESTART:   cmd.restart   = 1'b1;
            default:      cmd.start     = 1'b0;
          endcase
        end
      end
      ST_LOOK: cmd.look_rd = 1'b1;
      ST_LOOKW: begin
        if (sts.goto_valid || sts.s_zero) cmd.hit = 1'b1;
        else cmd.fail_rd = 1'b1;
      end
      ST_FAILW: cmd.fail_take = 1'b1;
      ST_INFO:  cmd.info_rd = 1'b1;
      ST_INFOW: cmd.cand_load = 1'b1;
      ST_SCAN:  if (!sts.scan_done) cmd.scan_rd = 1'b1;
      ST_SCANW: cmd.scan_cmp = 1'b1;
      ST_PUSH:  cmd.push = 1'b1;
      ST_CHAIN: begin
        if (sts.fnext_zero || sts.chain_done) cmd.drain_init = 1'b1;
        else cmd.chain_adv = 1'b1;
      end
      ST_DRD:   cmd.drain_rd = 1'b1;
      ST_DOUT: begin
        out_valid = 1'b1;
        if (out_ready && !sts.drain_last) cmd.drain_adv = 1'b1;
      end
      ST_DONE:  cmd.finish = 1'b1;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/mpbm_dp.sv =====
// Datapath: goto and state tables, walk registers and report buffer.
module mpbm_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpbm_pkg::cmd_t                cmd,
  output mpbm_pkg::sts_t                sts,
  input  logic [mpbm_pkg::ST_W-1:0]     state_index,
  input  logic [mpbm_pkg::SYM_W-1:0]    symbol,
  input  logic [mpbm_pkg::ST_W-1:0]     target_state,
  input  logic                          target_valid,
  input  logic [mpbm_pkg::ST_W-1:0]     failure_state,
  input  logic [mpbm_pkg::ID_W-1:0]     pattern_id,
  input  logic [mpbm_pkg::LEN_W-1:0]    pattern_length,
  output logic [mpbm_pkg::POS_W-1:0]    start_position,
  output logic [mpbm_pkg::ID_W-1:0]     matched_pattern,
  output logic                          last
);
  import mpbm_pkg::*;

  localparam int GOTO_DEPTH = STATES * SYMBOLS;
  localparam int INFO_AW    = ST_W;

  // memories
  logic [GOTO_W-1:0] goto_mem [GOTO_DEPTH];
  logic [ST_W-1:0]   fail_mem [STATES];
  logic [ID_W-1:0]   id_mem   [STATES];
  logic [LEN_W-1:0]  len_mem  [STATES];
  logic [BUF_W-1:0]  buf_mem  [MAX_RESULTS];

  logic [GOTO_W-1:0] goto_q_r;
  logic [ST_W-1:0]   fail_q_r;
  logic [ID_W-1:0]   id_q_r;
  logic [LEN_W-1:0]  len_q_r;
  logic [BUF_W-1:0]  buf_q_r;
  logic              last_r;

  logic [GOTO_AW-1:0] clr_r, clr_nxt;
  logic [ST_W-1:0]    cur_r, cur_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic [SYM_W-1:0]   sym_r, sym_nxt;
  logic [ST_W-1:0]    s_r, s_nxt;
  logic [CNT_W-1:0]   steps_r, steps_nxt;
  logic [ST_W-1:0]    f_r, f_nxt;
  logic [ST_W-1:0]    fnext_r, fnext_nxt;
  logic [CNT_W-1:0]   cst_r, cst_nxt;
  logic [CNT_W-1:0]   n_r, n_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic               dup_r, dup_nxt;
  logic [BUF_W-1:0]   cand_r, cand_nxt;

  logic               goto_we;
  logic [GOTO_AW-1:0] goto_wa;
  logic [GOTO_W-1:0]  goto_wd;
  logic               info_we;
  logic [INFO_AW-1:0] info_wa;
  logic [ST_W-1:0]    fail_wd;
  logic [ID_W-1:0]    id_wd;
  logic [LEN_W-1:0]   len_wd;
  logic [INFO_AW-1:0] fail_ra;
  logic [ST_W-1:0]    next_state;

  // table write ports: clearing pass or loads
  always_comb begin
    goto_we = cmd.clr_wr || cmd.load_goto;
    goto_wa = cmd.clr_wr ? clr_r : {state_index, symbol};
    goto_wd = (cmd.clr_wr || !target_valid) ? '0 : {1'b1, target_state};
    info_we = (cmd.clr_wr && clr_r[GOTO_AW-1:INFO_AW] == '0) || cmd.load_info;
    info_wa = cmd.clr_wr ? clr_r[INFO_AW-1:0] : state_index;
    fail_wd = cmd.clr_wr ? '0 : failure_state;
    id_wd   = cmd.clr_wr ? '0 : pattern_id;
    len_wd  = cmd.clr_wr ? '0 : pattern_length;
    fail_ra = cmd.fail_rd ? s_r : f_r;
  end

  always_ff @(posedge clk) begin
    if (goto_we) goto_mem[goto_wa] <= goto_wd;
    if (cmd.look_rd) goto_q_r <= goto_mem[{s_r, sym_r}];
  end

  always_ff @(posedge clk) begin
    if (info_we) begin
      fail_mem[info_wa] <= fail_wd;
      id_mem[info_wa]   <= id_wd;
      len_mem[info_wa]  <= len_wd;
    end
    if (cmd.fail_rd || cmd.info_rd) fail_q_r <= fail_mem[fail_ra];
    if (cmd.info_rd) begin
      id_q_r  <= id_mem[f_r];
      len_q_r <= len_mem[f_r];
    end
  end

  // report buffer: one write and one read port
  always_ff @(posedge clk) begin
    if (cmd.push) buf_mem[n_r[BUF_AW-1:0]] <= cand_r;
    if (cmd.scan_rd || cmd.drain_rd) buf_q_r <= buf_mem[j_r[BUF_AW-1:0]];
    if (cmd.drain_rd) last_r <= (j_r + 1'b1 == n_r);
  end

  assign next_state = goto_q_r[GOTO_W-1] ? goto_q_r[ST_W-1:0] : '0;

  // next values of walk and chain registers
  always_comb begin
    clr_nxt   = clr_r;
    cur_nxt   = cur_r;
    pos_nxt   = pos_r;
    sym_nxt   = sym_r;
    s_nxt     = s_r;
    steps_nxt = steps_r;
    f_nxt     = f_r;
    fnext_nxt = fnext_r;
    cst_nxt   = cst_r;
    n_nxt     = n_r;
    j_nxt     = j_r;
    dup_nxt   = dup_r;
    cand_nxt  = cand_r;
    if (cmd.clr_wr) clr_nxt = clr_r + 1'b1;
    if (cmd.restart) begin
      cur_nxt = '0;
      pos_nxt = '0;
    end
    if (cmd.start) begin
      sym_nxt   = symbol;
      s_nxt     = cur_r;
      steps_nxt = '0;
    end
    // follow a failure link; drop to the root once the walk runs too long
    if (cmd.fail_take) begin
      s_nxt     = (steps_r >= CNT_W'(MAX_PATTERN_LEN)) ? '0 : fail_q_r;
      steps_nxt = steps_r + 1'b1;
    end
    if (cmd.hit) begin
      cur_nxt = next_state;
      f_nxt   = next_state;
      n_nxt   = '0;
      cst_nxt = '0;
    end
    if (cmd.cand_load) begin
      cand_nxt  = {pos_r + POS_W'(1) - POS_W'(len_q_r), id_q_r};
      fnext_nxt = fail_q_r;
      j_nxt     = '0;
      dup_nxt   = 1'b0;
    end
    if (cmd.scan_cmp) begin
      if (buf_q_r == cand_r) dup_nxt = 1'b1;
      j_nxt = j_r + 1'b1;
    end
    if (cmd.push) n_nxt = n_r + 1'b1;
    if (cmd.chain_adv) begin
      f_nxt   = fnext_r;
      cst_nxt = cst_r + 1'b1;
    end
    if (cmd.drain_init) j_nxt = '0;
    if (cmd.drain_adv) j_nxt = j_r + 1'b1;
    if (cmd.finish) pos_nxt = pos_r + 1'b1;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      cur_r <= '0;
      pos_r <= '0;
      n_r   <= '0;
      j_r   <= '0;
      dup_r <= 1'b0;
      cst_r <= '0;
    end else begin
      clr_r <= clr_nxt;
      cur_r <= cur_nxt;
      pos_r <= pos_nxt;
      n_r   <= n_nxt;
      j_r   <= j_nxt;
      dup_r <= dup_nxt;
      cst_r <= cst_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    sym_r   <= sym_nxt;
    s_r     <= s_nxt;
    steps_r <= steps_nxt;
    f_r     <= f_nxt;
    fnext_r <= fnext_nxt;
    cand_r  <= cand_nxt;
  end

  // status to the controller
  always_comb begin
    sts.clr_done   = (clr_r == '1);
    sts.goto_valid = goto_q_r[GOTO_W-1];
    sts.s_zero     = (s_r == '0);
    sts.id_nonzero = (id_q_r != '0);
    sts.n_full     = (n_r == CNT_W'(MAX_RESULTS));
    sts.scan_done  = (j_r == n_r);
    sts.dup        = dup_r;
    sts.fnext_zero = (fnext_r == '0);
    sts.chain_done = (cst_r == CNT_W'(MAX_PATTERN_LEN));
    sts.n_zero     = (n_r == '0);
    sts.drain_last = last_r;
  end

  assign start_position  = buf_q_r[BUF_W-1:ID_W];
  assign matched_pattern = buf_q_r[ID_W-1:0];
  assign last            = last_r;

endmodule

// ===== rtl/core/multi_pattern_byte_matcher.sv =====
// Multi-pattern byte matcher: failure-link automaton; each byte is finished before the next item is taken.
// Reset starts a clearing pass over the goto and state tables; no transfer
// is taken during it. Restart returns to the root at position zero, tables kept.
// Loads and restart are done on acceptance. A byte is accepted, then walks goto probes and
// failure links, visits each state on its output chain (comparing earlier reports for a
// pattern and storing it if new), drains its reports with output stalls, and closes.
module multi_pattern_byte_matcher (
  input logic       clk,
  input logic       rst_n,
  mpbm_in_if.sink   in_ch,
  mpbm_out_if.source out_ch
);
  import mpbm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mpbm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_op     (op_t'(in_ch.operation)),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mpbm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .state_index     (in_ch.state_index),
    .symbol          (in_ch.symbol),
    .target_state    (in_ch.target_state),
    .target_valid    (in_ch.target_valid),
    .failure_state   (in_ch.failure_state),
    .pattern_id      (in_ch.pattern_id),
    .pattern_length  (in_ch.pattern_length),
    .start_position  (out_ch.start_position),
    .matched_pattern (out_ch.matched_pattern),
    .last            (out_ch.last)
  );

`ifndef SYNTHESIS
  // no new item while a report is on offer
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input ready during report");

  // reports never carry the empty pattern
  a_id_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.matched_pattern != '0) else $error("empty pattern reported");

  // nothing follows the final report of a byte
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.ready && out_ch.last |=> !out_ch.valid)
    else $error("report after last");
`endif

endmodule

// ===== sim/tb_top.sv =====
// Self-checking bench for the multi-pattern byte matcher: directed table, random stream, scoreboard.
module tb_top;
  import mpbm_pkg::*;

  typedef struct {
    op_t              op;
    logic [ST_W-1:0]  si;
    logic [SYM_W-1:0] sym;
    logic [ST_W-1:0]  tgt;
    logic             tv;
    logic [ST_W-1:0]  fs;
    logic [ID_W-1:0]  pid;
    logic [LEN_W-1:0] plen;
  } req_t;

  typedef struct {
    logic [POS_W-1:0] start;
    logic [ID_W-1:0]  id;
    logic             last;
  } report_t;

  // exp_n: -1 left to the predictor, 0 no report, 1 one report as typed
  typedef struct {
    req_t             r;
    int               exp_n;
    logic [POS_W-1:0] exp_start;
    logic [ID_W-1:0]  exp_id;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  mpbm_in_if  in_ch ();
  mpbm_out_if out_ch ();

  multi_pattern_byte_matcher DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // Shadow copy of the matcher tables and stream position
  logic [GOTO_W-1:0] goto_tab [STATES][SYMBOLS];
  logic [ST_W-1:0]   fail_tab [STATES];
  logic [ID_W-1:0]   id_tab   [STATES];
  logic [LEN_W-1:0]  len_tab  [STATES];
  logic [ST_W-1:0]   cur_state;
  logic [POS_W-1:0]  stream_pos;

  report_t  pending_reports [$];
  dir_row_t dir_tab [$];
  int errors;
  int mismatches_shown;
  int reports_seen;
  int bytes_matched;
  int items_sent;
  int burst_left;
  int max_reports;

  function automatic void add_report(ref report_t lst[$], input logic [ST_W-1:0] s);
    logic [POS_W-1:0] st;
    if (lst.size() >= MAX_RESULTS || id_tab[s] == '0) return;
    st = stream_pos + 32'd1 - POS_W'(len_tab[s]);
    foreach (lst[k])
      if (lst[k].start == st && lst[k].id == id_tab[s]) return;
    lst.push_back('{start: st, id: id_tab[s], last: 1'b0});
  endfunction

  // Walk the automaton for one accepted item; queue the reports it causes
  function automatic int apply_item(req_t r);
    report_t lst[$];
    logic [ST_W-1:0] s, nxt, f;
    int steps;
    case (r.op)
      OP_LOAD_GOTO: goto_tab[r.si][r.sym] = r.tv ? {1'b1, r.tgt} : '0;
      OP_LOAD_INFO: begin
        fail_tab[r.si] = r.fs;
        id_tab[r.si]   = r.pid;
        len_tab[r.si]  = r.plen;
      end
      OP_RESTART: begin
        cur_state  = '0;
        stream_pos = '0;
      end
      default: begin
        s = cur_state;
        steps = 0;
        forever begin
          if (goto_tab[s][r.sym][ST_W]) begin
            nxt = goto_tab[s][r.sym][ST_W-1:0];
            break;
          end
          if (s == '0) begin
            nxt = '0;
            break;
          end
          s = fail_tab[s];
          steps++;
          if (steps > MAX_PATTERN_LEN) s = '0;
        end
        cur_state = nxt;
        add_report(lst, nxt);
        f = nxt;
        for (int i = 0; i < MAX_PATTERN_LEN; i++) begin
          f = fail_tab[f];
          if (f == '0) break;
          add_report(lst, f);
        end
        if (lst.size() > 0) lst[lst.size()-1].last = 1'b1;
        foreach (lst[k]) pending_reports.push_back(lst[k]);
        if (lst.size() > max_reports) max_reports = lst.size();
        stream_pos = stream_pos + 32'd1;
        bytes_matched++;
      end
    endcase
    return lst.size();
  endfunction

  // Present one item, holding it until the transfer; gaps come between bursts
  task automatic send_item(req_t r, output int n);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(1, 10);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_ch.valid          <= 1'b1;
    in_ch.operation      <= r.op;
    in_ch.state_index    <= r.si;
    in_ch.symbol         <= r.sym;
    in_ch.target_state   <= r.tgt;
    in_ch.target_valid   <= r.tv;
    in_ch.failure_state  <= r.fs;
    in_ch.pattern_id     <= r.pid;
    in_ch.pattern_length <= r.plen;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n = apply_item(r);
    items_sent++;
    burst_left--;
  endtask

  function automatic dir_row_t mk(op_t op, int si, int sym, int tgt, int tv, int fs,
                                  int pid, int plen, int exp_n = -1, int es = 0,
                                  int eid = 0);
    dir_row_t d;
    d.r = '{op: op, si: ST_W'(si), sym: SYM_W'(sym), tgt: ST_W'(tgt), tv: tv[0],
            fs: ST_W'(fs), pid: ID_W'(pid), plen: LEN_W'(plen)};
    d.exp_n = exp_n;
    d.exp_start = POS_W'(es);
    d.exp_id = ID_W'(eid);
    return d;
  endfunction

  function automatic req_t rand_req();
    req_t r;
    int pick;
    r.si   = ST_W'($urandom_range(0, 15));
    r.sym  = SYM_W'(8'h61 + $urandom_range(0, 3));
    r.tgt  = ST_W'($urandom_range(0, 15));
    r.tv   = ($urandom_range(0, 5) != 0);
    r.fs   = ST_W'($urandom_range(0, 15));
    r.pid  = ($urandom_range(0, 4) == 0) ? '0 : ID_W'($urandom_range(1, PATTERN_IDS - 1));
    r.plen = ($urandom_range(0, 5) == 0) ? LEN_W'($urandom_range(0, 127))
                                          : LEN_W'($urandom_range(0, 6));
    pick = $urandom_range(0, 99);
    if (pick < 60) r.op = OP_MATCH;
    else if (pick < 77) r.op = OP_LOAD_GOTO;
    else if (pick < 95) r.op = OP_LOAD_INFO;
    else r.op = OP_RESTART;
    // noise: any value in every field but the operation
    if ($urandom_range(0, 9) == 0) begin
      r.si   = ST_W'($urandom());
      r.sym  = SYM_W'($urandom());
      r.tgt  = ST_W'($urandom());
      r.tv   = 1'($urandom());
      r.fs   = ST_W'($urandom());
      r.pid  = ID_W'($urandom());
      r.plen = LEN_W'($urandom());
    end
    return r;
  endfunction

  // Receiver: random stalls at a changing rate; compare each transfer in order
  int rdy_pct = 100;
  int rdy_cnt = 0;
  initial out_ch.ready = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        reports_seen++;
        if (pending_reports.size() == 0) begin
          errors++;
          if (mismatches_shown < 10) begin
            mismatches_shown++;
            $display("unexpected report: start=%0d id=%0d last=%0b",
                     out_ch.start_position, out_ch.matched_pattern, out_ch.last);
          end
        end else begin
          report_t e;
          e = pending_reports.pop_front();
          if (out_ch.start_position !== e.start || out_ch.matched_pattern !== e.id ||
              out_ch.last !== e.last) begin
            errors++;
            if (mismatches_shown < 10) begin
              mismatches_shown++;
              $display("report mismatch: expected start=%0d id=%0d last=%0b, got %0d %0d %0b",
                       e.start, e.id, e.last, out_ch.start_position,
                       out_ch.matched_pattern, out_ch.last);
            end
          end
        end
      end
      rdy_cnt++;
      if (rdy_cnt % 64 == 0) rdy_pct = ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(20, 80);
      out_ch.ready <= ($urandom_range(0, 99) < rdy_pct);
    end
  end

  // Main sequence
  initial begin
    req_t r;
    int n;
    in_ch.valid          <= 1'b0;
    in_ch.operation      <= OP_RESTART;
    in_ch.state_index    <= '0;
    in_ch.symbol         <= '0;
    in_ch.target_state   <= '0;
    in_ch.target_valid   <= 1'b0;
    in_ch.failure_state  <= '0;
    in_ch.pattern_id     <= '0;
    in_ch.pattern_length <= '0;
    foreach (goto_tab[i, j]) goto_tab[i][j] = '0;
    foreach (fail_tab[i]) begin
      fail_tab[i] = '0;
      id_tab[i]   = '0;
      len_tab[i]  = '0;
    end
    cur_state = '0;
    stream_pos = '0;
    errors = 0;
    mismatches_shown = 0;
    reports_seen = 0;
    bytes_matched = 0;
    items_sent = 0;
    burst_left = 0;
    max_reports = 0;

    // directed: extremes, root pattern, wrap of start, duplicates, failure loop
    dir_tab.push_back(mk(OP_MATCH,     0, 8'hFF, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_LOAD_GOTO, 0, 8'h61, 1, 1, 0, 0, 0));
    dir_tab.push_back(mk(OP_LOAD_INFO, 1, 0, 0, 0, 0, 1023, 1));
    dir_tab.push_back(mk(OP_MATCH,     0, 8'h61, 0, 0, 0, 0, 0, 1, 1, 1023));
    dir_tab.push_back(mk(OP_LOAD_GOTO, 1, 8'h62, 1023, 1, 0, 0, 0));
    dir_tab.push_back(mk(OP_LOAD_INFO, 1023, 0, 0, 0, 1, 5, 127));
    dir_tab.push_back(mk(OP_MATCH,     0, 8'h62, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_MATCH,     0, 8'h62, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_RESTART,   0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_LOAD_INFO, 0, 0, 0, 0, 0, 7, 0));
    dir_tab.push_back(mk(OP_MATCH,     0, 8'h7A, 0, 0, 0, 0, 0, 1, 1, 7));
    dir_tab.push_back(mk(OP_LOAD_INFO, 0, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_LOAD_GOTO, 0, 8'h63, 2, 1, 0, 0, 0));
    dir_tab.push_back(mk(OP_LOAD_INFO, 2, 0, 0, 0, 3, 9, 2));
    dir_tab.push_back(mk(OP_LOAD_INFO, 3, 0, 0, 0, 2, 9, 2));
    dir_tab.push_back(mk(OP_MATCH,     0, 8'h63, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_LOAD_GOTO, 2, 8'h63, 3, 1, 0, 0, 0));
    dir_tab.push_back(mk(OP_MATCH,     0, 8'h63, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_LOAD_GOTO, 3, 8'h64, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_MATCH,     0, 8'h64, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_LOAD_GOTO, 0, 8'h61, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_MATCH,     0, 8'h61, 0, 0, 0, 0, 0, 0));
    dir_tab.push_back(mk(OP_LOAD_GOTO, 1023, 8'hFF, 1023, 1, 0, 0, 0));
    dir_tab.push_back(mk(OP_MATCH,     0, 8'h00, 0, 0, 0, 0, 0));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) begin
      send_item(dir_tab[i].r, n);
      if (dir_tab[i].exp_n >= 0 &&
          (n != dir_tab[i].exp_n ||
           (n == 1 && (pending_reports[$].start != dir_tab[i].exp_start ||
                       pending_reports[$].id != dir_tab[i].exp_id)))) begin
        errors++;
        if (mismatches_shown < 10) begin
          mismatches_shown++;
          $display("directed row %0d: predicted %0d reports, table says %0d",
                   i, n, dir_tab[i].exp_n);
        end
      end
    end

    // long failure chain with distinct ids: more candidates than the report cap
    for (int i = 0; i < 70; i++) begin
      r = '{op: OP_LOAD_INFO, si: ST_W'(200 + i), sym: 0, tgt: 0, tv: 0,
            fs: (i == 69) ? '0 : ST_W'(201 + i), pid: ID_W'(300 + i),
            plen: LEN_W'(i % 5)};
      send_item(r, n);
    end
    r = '{op: OP_LOAD_GOTO, si: 0, sym: 8'h71, tgt: 200, tv: 1, fs: 0, pid: 0, plen: 0};
    send_item(r, n);
    r.op = OP_MATCH;
    send_item(r, n);
    send_item(r, n);

    // random stream over a small alphabet and a small automaton
    for (int i = 0; i < 130; i++) begin
      r = rand_req();
      send_item(r, n);
    end
    in_ch.valid <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d items, %0d bytes matched, %0d reports checked (most per byte %0d).",
             items_sent, bytes_matched, reports_seen, max_reports);
    if (errors == 0)
      $display("multi_pattern_byte_matcher verification clean");
    else
      $display("multi_pattern_byte_matcher verification failed");
    $finish;
  end

  // Hard stop: clearing pass plus worst-case byte handling, with ample margin
  initial begin
    #(10 * 20_000_000);
    $display("multi_pattern_byte_matcher verification failed");
    $finish;
  end

endmodule

// ===== multi_pattern_byte_matcher.f =====
rtl/core/mpbm_pkg.sv
rtl/core/mpbm_in_if.sv
rtl/core/mpbm_out_if.sv
rtl/core/mpbm_ctrl.sv
rtl/core/mpbm_dp.sv
rtl/core/multi_pattern_byte_matcher.sv
sim/tb_top.sv
